// ----- design/mcce_pkg.sv -----
`default_nettype none
package mcce_pkg;

  localparam int NLANE    = 5;
  localparam int POS_BITS = 16;
  localparam int OTH_BITS = 12;
  localparam int QUO_W    = 16;
  localparam int VAL_W    = 32;
  localparam int REM_W    = VAL_W + QUO_W;
  localparam int NDIV     = QUO_W;

  // lane order follows the frame packing order
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_KP  = 2;
  localparam int LANE_KD  = 3;
  localparam int LANE_T   = 4;

  localparam logic signed [VAL_W:0] STIFFNESS_MIN = '0;
  localparam logic signed [VAL_W:0] DAMPING_MIN   = '0;

  localparam logic [63:0] FRAME_ENABLE  = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] FRAME_DISABLE = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] FRAME_ZERO    = 64'hFFFF_FFFF_FFFF_FFFE;

  typedef enum logic [1:0] {
    OP_MOTION  = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_ZERO    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_POS_MIN    = 3'd0,
    REG_POS_MAX    = 3'd1,
    REG_VEL_MIN    = 3'd2,
    REG_VEL_MAX    = 3'd3,
    REG_TORQUE_MIN = 3'd4,
    REG_TORQUE_MAX = 3'd5,
    REG_STIFF_MAX  = 3'd6,
    REG_DAMP_MAX   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   span;
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } lane_t;

  function automatic int lane_bits(input int l);
    return (l == LANE_POS) ? POS_BITS : OTH_BITS;
  endfunction

endpackage
`default_nettype wire

// ----- design/motor_can_command_encoder.sv -----
`default_nettype none
// Motor command frame encoder for a mini-cheetah style CAN motor controller.
// Each input transaction yields exactly one 64-bit payload transaction, byte 0
// in the top byte. A motion command (op 0) clamps position, velocity,
// stiffness, damping and feed-forward torque to their configured ranges and
// quantizes each one as floor((x-min)*(2^bits-1)/(max-min)): 16 bits for
// position, 12 bits for the rest; a range whose span is not positive gives
// code 0. Ops 1, 2 and 3 give the fixed enable, disable and zero-encoder
// frames. All values are signed Q16.16. The block is fully pipelined: one
// transaction per cycle, with registered steps from input to output register
// (clamp, offset, scale, sixteen restoring-division stages of one quotient
// bit each, frame pack). A stall on the output holds the whole pipeline.
// Write range registers only while no transaction is in flight.
module motor_can_command_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic signed [31:0] in_target_pos,
  input  wire logic signed [31:0] in_target_vel,
  input  wire logic signed [31:0] in_stiffness,
  input  wire logic signed [31:0] in_damping,
  input  wire logic signed [31:0] in_torque_ff,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_payload
);

  localparam int NL = mcce_pkg::NLANE;
  localparam int VW = mcce_pkg::VAL_W;
  localparam int RW = mcce_pkg::REM_W;
  localparam int QW = mcce_pkg::QUO_W;
  localparam int ND = mcce_pkg::NDIV;

  // ---------------- range registers ----------------
  logic signed [31:0] pos_min_r, pos_max_r, vel_min_r, vel_max_r;
  logic signed [31:0] torque_min_r, torque_max_r;
  logic [30:0]        stiff_max_r, damp_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r    <= -32'sd819200;
      pos_max_r    <= 32'sd819200;
      vel_min_r    <= -32'sd2949120;
      vel_max_r    <= 32'sd2949120;
      torque_min_r <= -32'sd1179648;
      torque_max_r <= 32'sd1179648;
      stiff_max_r  <= 31'd32768000;
      damp_max_r   <= 31'd327680;
    end else if (cfg_we) begin
      unique case (mcce_pkg::reg_idx_t'(cfg_index))
        mcce_pkg::REG_POS_MIN:    pos_min_r    <= cfg_wdata;
        mcce_pkg::REG_POS_MAX:    pos_max_r    <= cfg_wdata;
        mcce_pkg::REG_VEL_MIN:    vel_min_r    <= cfg_wdata;
        mcce_pkg::REG_VEL_MAX:    vel_max_r    <= cfg_wdata;
        mcce_pkg::REG_TORQUE_MIN: torque_min_r <= cfg_wdata;
        mcce_pkg::REG_TORQUE_MAX: torque_max_r <= cfg_wdata;
        mcce_pkg::REG_STIFF_MAX:  stiff_max_r  <= cfg_wdata[30:0];
        mcce_pkg::REG_DAMP_MAX:   damp_max_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Stall-all: every stage advances together when the output can move.
  logic advance;
  logic out_valid_r;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign out_valid = out_valid_r;

  // ---------------- stage A: clamp and span ----------------
  logic signed [VW:0] x_ext [NL];
  logic signed [VW:0] lo_ext [NL];
  logic signed [VW:0] hi_ext [NL];
  logic signed [VW:0] clamp_lo [NL];
  logic signed [VW:0] v_a_nxt [NL];
  logic signed [VW:0] sp_a_nxt [NL];

  logic               a_val_r;
  logic [1:0]         a_op_r;
  logic signed [VW:0] a_v_r  [NL];
  logic signed [VW:0] a_lo_r [NL];
  logic signed [VW:0] a_sp_r [NL];

  always_comb begin
    x_ext[mcce_pkg::LANE_POS] = {in_target_pos[31], in_target_pos};
    x_ext[mcce_pkg::LANE_VEL] = {in_target_vel[31], in_target_vel};
    x_ext[mcce_pkg::LANE_KP]  = {in_stiffness[31], in_stiffness};
    x_ext[mcce_pkg::LANE_KD]  = {in_damping[31], in_damping};
    x_ext[mcce_pkg::LANE_T]   = {in_torque_ff[31], in_torque_ff};
    lo_ext[mcce_pkg::LANE_POS] = {pos_min_r[31], pos_min_r};
    hi_ext[mcce_pkg::LANE_POS] = {pos_max_r[31], pos_max_r};
    lo_ext[mcce_pkg::LANE_VEL] = {vel_min_r[31], vel_min_r};
    hi_ext[mcce_pkg::LANE_VEL] = {vel_max_r[31], vel_max_r};
    lo_ext[mcce_pkg::LANE_KP]  = mcce_pkg::STIFFNESS_MIN;
    hi_ext[mcce_pkg::LANE_KP]  = {2'b00, stiff_max_r};
    lo_ext[mcce_pkg::LANE_KD]  = mcce_pkg::DAMPING_MIN;
    hi_ext[mcce_pkg::LANE_KD]  = {2'b00, damp_max_r};
    lo_ext[mcce_pkg::LANE_T]   = {torque_min_r[31], torque_min_r};
    hi_ext[mcce_pkg::LANE_T]   = {torque_max_r[31], torque_max_r};
    for (int l = 0; l < NL; l++) begin
      // raise to min first, then lower to max: an inverted range ends at max
      clamp_lo[l] = (x_ext[l] < lo_ext[l]) ? lo_ext[l] : x_ext[l];
      v_a_nxt[l]  = (clamp_lo[l] > hi_ext[l]) ? hi_ext[l] : clamp_lo[l];
      sp_a_nxt[l] = hi_ext[l] - lo_ext[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_val_r <= 1'b0;
    end else if (advance) begin
      a_val_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_op_r <= in_op;
      for (int l = 0; l < NL; l++) begin
        a_v_r[l]  <= v_a_nxt[l];
        a_lo_r[l] <= lo_ext[l];
        a_sp_r[l] <= sp_a_nxt[l];
      end
    end
  end

  // ---------------- stage B: offset from min, span check ----------------
  logic signed [VW:0] d_b_nxt [NL];
  logic               b_val_r;
  logic [1:0]         b_op_r;
  logic [VW-1:0]      b_d_r  [NL];
  logic [VW-1:0]      b_sp_r [NL];
  logic               b_ok_r [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      d_b_nxt[l] = a_v_r[l] - a_lo_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_val_r <= 1'b0;
    end else if (advance) begin
      b_val_r <= a_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_op_r <= a_op_r;
      for (int l = 0; l < NL; l++) begin
        // with a positive span the offset lies in [0, span] and fits 32 bits
        b_d_r[l]  <= d_b_nxt[l][VW-1:0];
        b_sp_r[l] <= a_sp_r[l][VW-1:0];
        b_ok_r[l] <= !a_sp_r[l][VW] && (|a_sp_r[l][VW-1:0]);
      end
    end
  end

  // ---------------- stage C: scale by 2^bits-1 ----------------
  mcce_pkg::lane_t scl_nxt [NL];
  logic [RW-1:0]   d_wide  [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      d_wide[l]       = {{(RW-VW){1'b0}}, b_d_r[l]};
      scl_nxt[l].ok   = b_ok_r[l];
      scl_nxt[l].span = b_sp_r[l];
      scl_nxt[l].rem  = (d_wide[l] << mcce_pkg::lane_bits(l)) - d_wide[l];
      scl_nxt[l].quo  = '0;
    end
  end

  // dv_r[0] is the scaled operand; dv_r[k+1] follows division step k
  logic            dv_val_r [ND+1];
  logic [1:0]      dv_op_r  [ND+1];
  mcce_pkg::lane_t dv_r     [ND+1][NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_val_r[0] <= 1'b0;
    end else if (advance) begin
      dv_val_r[0] <= b_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_op_r[0] <= b_op_r;
      for (int l = 0; l < NL; l++) begin
        dv_r[0][l] <= scl_nxt[l];
      end
    end
  end

  // ---------------- division stages: one quotient bit each ----------------
  // Quotient never exceeds 2^bits-1, so subtract span<<i for i from the top
  // quotient bit down; 12-bit lanes pass through the first four stages.
  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int SH = ND - 1 - k;
    mcce_pkg::lane_t stp_nxt [NL];
    logic [RW:0]     trial   [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        stp_nxt[l] = dv_r[k][l];
        trial[l]   = {1'b0, dv_r[k][l].rem}
                   - ({{(RW+1-VW){1'b0}}, dv_r[k][l].span} << SH);
        if ((SH < mcce_pkg::lane_bits(l)) && !trial[l][RW]) begin
          stp_nxt[l].rem     = trial[l][RW-1:0];
          stp_nxt[l].quo[SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_val_r[k+1] <= 1'b0;
      end else if (advance) begin
        dv_val_r[k+1] <= dv_val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_op_r[k+1] <= dv_op_r[k];
        for (int l = 0; l < NL; l++) begin
          dv_r[k+1][l] <= stp_nxt[l];
        end
      end
    end
  end

  // ---------------- frame pack and output register ----------------
  logic [QW-1:0] code [NL];
  logic [63:0]   payload_nxt;
  logic [63:0]   payload_r;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      code[l] = dv_r[ND][l].ok ? dv_r[ND][l].quo : '0;
    end
    unique case (mcce_pkg::op_t'(dv_op_r[ND]))
      mcce_pkg::OP_ENABLE:  payload_nxt = mcce_pkg::FRAME_ENABLE;
      mcce_pkg::OP_DISABLE: payload_nxt = mcce_pkg::FRAME_DISABLE;
      mcce_pkg::OP_ZERO:    payload_nxt = mcce_pkg::FRAME_ZERO;
      default: payload_nxt = {code[mcce_pkg::LANE_POS][15:0],
                              code[mcce_pkg::LANE_VEL][11:0],
                              code[mcce_pkg::LANE_KP][11:0],
                              code[mcce_pkg::LANE_KD][11:0],
                              code[mcce_pkg::LANE_T][11:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dv_val_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      payload_r <= payload_nxt;
    end
  end

  assign out_payload = payload_r;

endmodule
`default_nettype wire
